### hw/rtl/fhm_pkg.sv
// Shared types and constants of the mutex lock manager with its FIFO wait queue.
`default_nettype none

package fhm_pkg;

	// Default sizes handed to the top level parameters.
	localparam int JOB_ID_BITS_DEF = 4;
	localparam int QUEUE_DEPTH_DEF = 16;

	// Operation codes of a request.
	typedef enum logic [1:0] {
		OP_LOCK    = 2'd0,
		OP_TRYLOCK = 2'd1,
		OP_UNLOCK  = 2'd2,
		OP_CANCEL  = 2'd3
	} opcode_t;

	// Status codes of a result.
	typedef enum logic [2:0] {
		ST_GRANTED  = 3'd0,
		ST_QUEUED   = 3'd1,
		ST_BUSY     = 3'd2,
		ST_RELEASED = 3'd3,
		ST_REMOVED  = 3'd4,
		ST_NOTFOUND = 3'd5,
		ST_MISUSE   = 3'd6
	} status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_POP,
		S_FIN
	} state_t;

	// Control part of a finished result travelling to the output register.
	typedef struct packed {
		status_t status;
		logic    wake_valid;
		logic    owner_valid;
	} res_flags_t;

endpackage

`default_nettype wire

### hw/rtl/fhm_req_if.sv
// Request channel: opcode and job identifier with a valid/ready handshake.
`default_nettype none

interface fhm_req_if import fhm_pkg::*; #(
	parameter int JOB_ID_BITS = JOB_ID_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [1:0]             opcode;
	logic [JOB_ID_BITS-1:0] job_id;

	modport source (output valid, output opcode, output job_id, input ready);
	modport sink   (input valid, input opcode, input job_id, output ready);
endinterface

`default_nettype wire

### hw/rtl/fhm_rsp_if.sv
// Result channel: status, woken job and owner with a valid/ready handshake.
`default_nettype none

interface fhm_rsp_if import fhm_pkg::*; #(
	parameter int JOB_ID_BITS = JOB_ID_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [2:0]             status;
	logic                   wake_valid;
	logic [JOB_ID_BITS-1:0] wake_job;
	logic                   owner_valid;
	logic [JOB_ID_BITS-1:0] owner_job;

	modport source (output valid, output status, output wake_valid, output wake_job,
		output owner_valid, output owner_job, input ready);
	modport sink   (input valid, input status, input wake_valid, input wake_job,
		input owner_valid, input owner_job, output ready);
endinterface

`default_nettype wire

### hw/rtl/fhm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module fhm_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

`default_nettype wire

### hw/rtl/fhm_ctrl.sv
// Lock state and the controller that searches, appends and compacts the wait queue.
`default_nettype none

module fhm_ctrl import fhm_pkg::*; #(
	parameter int JOB_ID_BITS = JOB_ID_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	fhm_req_if.sink                req,
	output logic                   res_valid,
	input  logic                   res_ready,
	output res_flags_t             res_flags,
	output logic [JOB_ID_BITS-1:0] res_wake_job,
	output logic [JOB_ID_BITS-1:0] res_owner_job
);
	localparam int IW = JOB_ID_BITS;
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

	// Circular successor and predecessor of a queue address.
	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == LAST) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? LAST : p - AW'(1);
	endfunction

	state_t        state_q, state_d;
	logic          held_q, held_d;
	logic [IW-1:0] owner_q, owner_d;
	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] tail_q, tail_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [CW-1:0] idx_q, idx_d;
	opcode_t       op_q, op_d;
	logic [IW-1:0] job_q, job_d;
	status_t       status_q, status_d;
	logic          wake_v_q, wake_v_d;
	logic [IW-1:0] wake_j_q, wake_j_d;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [IW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [IW-1:0] ram_rdata;
	logic          last_entry;

	// Wait queue storage. The read for the next entry and the write of a shifted
	// entry never address the same word in flight, so no forwarding is needed.
	fhm_ram #(
		.WIDTH(IW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign last_entry = ((idx_q + CW'(1)) == count_q);

	// Next state, queue accesses and result.
	always_comb begin
		state_d   = state_q;
		held_d    = held_q;
		owner_d   = owner_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		idx_d     = idx_q;
		op_d      = op_q;
		job_d     = job_q;
		status_d  = status_q;
		wake_v_d  = wake_v_q;
		wake_j_d  = wake_j_q;
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = job_q;
		ram_re    = 1'b0;
		ram_raddr = ptr_inc(ptr_q);
		req.ready = 1'b0;
		res_valid = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					op_d     = opcode_t'(req.opcode);
					job_d    = req.job_id;
					wake_v_d = 1'b0;
					wake_j_d = '0;
					state_d  = S_FIN;
					unique case (opcode_t'(req.opcode))
						OP_LOCK: begin
							if (!held_q) begin
								held_d   = 1'b1;
								owner_d  = req.job_id;
								status_d = ST_GRANTED;
							end else if (owner_q == req.job_id) begin
								status_d = ST_MISUSE;
							end else if (count_q == '0) begin
								// Empty queue: append at once.
								ram_we    = 1'b1;
								ram_wdata = req.job_id;
								tail_d    = ptr_inc(tail_q);
								count_d   = count_q + CW'(1);
								status_d  = ST_QUEUED;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = head_q;
								ptr_d     = head_q;
								idx_d     = '0;
								state_d   = S_SCAN;
							end
						end
						OP_TRYLOCK: begin
							if (held_q) begin
								status_d = ST_BUSY;
							end else begin
								held_d   = 1'b1;
								owner_d  = req.job_id;
								status_d = ST_GRANTED;
							end
						end
						OP_UNLOCK: begin
							if (!held_q || owner_q != req.job_id) begin
								status_d = ST_MISUSE;
							end else if (count_q != '0) begin
								ram_re    = 1'b1;
								ram_raddr = head_q;
								state_d   = S_POP;
							end else begin
								held_d   = 1'b0;
								owner_d  = '0;
								status_d = ST_RELEASED;
							end
						end
						OP_CANCEL: begin
							if (count_q == '0) begin
								status_d = ST_NOTFOUND;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = head_q;
								ptr_d     = head_q;
								idx_d     = '0;
								state_d   = S_SCAN;
							end
						end
						default: begin
							status_d = ST_MISUSE;
						end
					endcase
				end
			end

			// One queue entry is compared per cycle, head first.
			S_SCAN: begin
				if (ram_rdata == job_q) begin
					if (op_q == OP_LOCK) begin
						status_d = ST_MISUSE;
						state_d  = S_FIN;
					end else begin
						wake_v_d = 1'b1;
						wake_j_d = job_q;
						status_d = ST_REMOVED;
						state_d  = S_SHIFT_RD;
					end
				end else if (last_entry) begin
					state_d = S_FIN;
					if (op_q == OP_LOCK) begin
						if (count_q == FULL) begin
							status_d = ST_BUSY;
						end else begin
							ram_we   = 1'b1;
							tail_d   = ptr_inc(tail_q);
							count_d  = count_q + CW'(1);
							status_d = ST_QUEUED;
						end
					end else begin
						status_d = ST_NOTFOUND;
					end
				end else begin
					ram_re = 1'b1;
					ptr_d  = ptr_inc(ptr_q);
					idx_d  = idx_q + CW'(1);
				end
			end

			// Close the gap left by a cancelled job: read the next entry.
			S_SHIFT_RD: begin
				if (last_entry) begin
					count_d = count_q - CW'(1);
					tail_d  = ptr_dec(tail_q);
					state_d = S_FIN;
				end else begin
					ram_re  = 1'b1;
					state_d = S_SHIFT_WR;
				end
			end

			// ...and write it one place nearer the head.
			S_SHIFT_WR: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = ram_rdata;
				ptr_d     = ptr_inc(ptr_q);
				idx_d     = idx_q + CW'(1);
				state_d   = S_SHIFT_RD;
			end

			// Hand the mutex to the head waiter.
			S_POP: begin
				owner_d  = ram_rdata;
				head_d   = ptr_inc(head_q);
				count_d  = count_q - CW'(1);
				wake_v_d = 1'b1;
				wake_j_d = ram_rdata;
				status_d = ST_RELEASED;
				state_d  = S_FIN;
			end

			S_FIN: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Lock state and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 1'b0;
			owner_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			ptr_q   <= '0;
			idx_q   <= '0;
		end else begin
			held_q  <= held_d;
			owner_q <= owner_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			ptr_q   <= ptr_d;
			idx_q   <= idx_d;
		end
	end

	// Request and result payload.
	always_ff @(posedge clk) begin
		op_q     <= op_d;
		job_q    <= job_d;
		status_q <= status_d;
		wake_v_q <= wake_v_d;
		wake_j_q <= wake_j_d;
	end

	assign res_flags.status      = status_q;
	assign res_flags.wake_valid  = wake_v_q;
	assign res_flags.owner_valid = held_q;
	assign res_wake_job          = wake_j_q;
	assign res_owner_job         = held_q ? owner_q : '0;
endmodule

`default_nettype wire

### hw/rtl/fhm_out.sv
// Output register that holds a finished result until the sink takes it.
`default_nettype none

module fhm_out import fhm_pkg::*; #(
	parameter int JOB_ID_BITS = JOB_ID_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   res_valid,
	output logic                   res_ready,
	input  res_flags_t             res_flags,
	input  logic [JOB_ID_BITS-1:0] res_wake_job,
	input  logic [JOB_ID_BITS-1:0] res_owner_job,
	fhm_rsp_if.source              rsp
);
	logic                   valid_q;
	res_flags_t             flags_q;
	logic [JOB_ID_BITS-1:0] wake_job_q;
	logic [JOB_ID_BITS-1:0] owner_job_q;

	// The register takes a new result when empty or when its content leaves.
	assign res_ready = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			flags_q     <= res_flags;
			wake_job_q  <= res_wake_job;
			owner_job_q <= res_owner_job;
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.status      = flags_q.status;
	assign rsp.wake_valid  = flags_q.wake_valid;
	assign rsp.wake_job    = wake_job_q;
	assign rsp.owner_valid = flags_q.owner_valid;
	assign rsp.owner_job   = owner_job_q;
endmodule

`default_nettype wire

### hw/rtl/fifo_handoff_mutex_core.sv
// Top level of the mutex lock manager with a FIFO wait queue held in RAM.
// Trylock, lock of a free mutex or by its owner, unlock, and any request on an empty queue
// are decided at once; unlock with waiters first reads the head of the queue; lock of a held
// mutex by another job and cancel scan the queue from the head, and cancel of a waiter then
// moves each later entry one place nearer the head. One request at a time.
// Asynchronous reset frees the mutex and empties the queue; the queue RAM is not cleared.
`default_nettype none

module fifo_handoff_mutex_core import fhm_pkg::*; #(
	parameter int JOB_ID_BITS = JOB_ID_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	fhm_req_if.sink   req,
	fhm_rsp_if.source rsp
);
	logic                   res_valid;
	logic                   res_ready;
	res_flags_t             res_flags;
	logic [JOB_ID_BITS-1:0] res_wake_job;
	logic [JOB_ID_BITS-1:0] res_owner_job;

	// Lock state, queue and controller.
	fhm_ctrl #(
		.JOB_ID_BITS (JOB_ID_BITS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res_flags     (res_flags),
		.res_wake_job  (res_wake_job),
		.res_owner_job (res_owner_job)
	);

	// Result register.
	fhm_out #(
		.JOB_ID_BITS (JOB_ID_BITS)
	) u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res_flags     (res_flags),
		.res_wake_job  (res_wake_job),
		.res_owner_job (res_owner_job),
		.rsp           (rsp)
	);
endmodule

`default_nettype wire

### hw/rtl/fhm_checker.sv
// Port-level assertions for the lock manager and their binding to the top level.
`default_nettype none

module fhm_checker import fhm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	fhm_req_if.sink   req,
	fhm_rsp_if.source rsp
);
	// A result that waits stays valid and keeps its status.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
		else $error("result changed while stalled");

	// One request is in work at a time.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while another is in work");

	// A free mutex reports owner zero.
	a_free_owner: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.owner_valid |-> rsp.owner_job == '0)
		else $error("owner reported for a free mutex");

	// Granting or queueing leaves the mutex held and wakes no job.
	a_grant_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_GRANTED || rsp.status == ST_QUEUED)
		|-> rsp.owner_valid && !rsp.wake_valid)
		else $error("grant or queue without a held mutex");

	// A cancelled waiter is always woken.
	a_removed_wakes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_REMOVED |-> rsp.wake_valid)
		else $error("removed job not woken");
endmodule

bind fifo_handoff_mutex_core fhm_checker u_fhm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);

`default_nettype wire

### tb/sv/fhm_lock_checker.sv
// Checker of the mutex lock manager: predicts every result from the requests and compares.
`default_nettype none

module fhm_lock_checker import fhm_pkg::*; #(
	parameter int JOB_ID_BITS = JOB_ID_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	fhm_req_if                          req,
	fhm_rsp_if                          rsp,
	output int                          fail_count,
	output int                          outstanding,
	output logic                        held_hint,
	output logic [JOB_ID_BITS-1:0]      owner_hint,
	output logic [(1<<JOB_ID_BITS)-1:0] waiting_mask
);
	localparam int N_JOBS = 1 << JOB_ID_BITS;

	typedef logic [JOB_ID_BITS-1:0] job_t;

	typedef struct packed {
		status_t status;
		logic    wake_valid;
		job_t    wake_job;
		logic    owner_valid;
		job_t    owner_job;
	} lock_outcome_t;

	// Own copy of the mutex state, advanced once per accepted request.
	logic          mutex_held = 1'b0;
	job_t          mutex_owner = '0;
	job_t          wait_line[$];
	lock_outcome_t owed_outcomes[$];

	// Values handed to the stimulus side, updated after each edge.
	int                mismatches = 0;
	int                owed_count = 0;
	logic              held_seen = 1'b0;
	job_t              owner_seen = '0;
	logic [N_JOBS-1:0] waiting_seen = '0;

	assign fail_count   = mismatches;
	assign outstanding  = owed_count;
	assign held_hint    = held_seen;
	assign owner_hint   = owner_seen;
	assign waiting_mask = waiting_seen;

	// Prints one line per disagreement and counts it.
	task automatic report_mismatch(string what, int got, int want);
		$display("lock manager mismatch: %s is %0d, expected %0d", what, got, want);
		mismatches++;
	endtask

	// Works out the result of one request and moves the mutex state on.
	function automatic lock_outcome_t predict_lock_outcome(opcode_t op, job_t job);
		lock_outcome_t o;
		int at;
		o = '0;
		o.status = ST_MISUSE;
		at = -1;
		foreach (wait_line[i]) begin
			if (at < 0 && wait_line[i] == job) at = i;
		end
		case (op)
			OP_LOCK: begin
				if (!mutex_held) begin
					mutex_held = 1'b1;
					mutex_owner = job;
					o.status = ST_GRANTED;
				end else if (mutex_owner == job || at >= 0) begin
					o.status = ST_MISUSE;
				end else if (wait_line.size() >= QUEUE_DEPTH) begin
					o.status = ST_BUSY;
				end else begin
					wait_line.push_back(job);
					o.status = ST_QUEUED;
				end
			end
			OP_TRYLOCK: begin
				if (mutex_held) begin
					o.status = ST_BUSY;
				end else begin
					mutex_held = 1'b1;
					mutex_owner = job;
					o.status = ST_GRANTED;
				end
			end
			OP_UNLOCK: begin
				if (!mutex_held || mutex_owner != job) begin
					o.status = ST_MISUSE;
				end else if (wait_line.size() > 0) begin
					// Ownership passes straight to the head of the queue.
					mutex_owner = wait_line.pop_front();
					o.wake_valid = 1'b1;
					o.wake_job = mutex_owner;
					o.status = ST_RELEASED;
				end else begin
					mutex_held = 1'b0;
					mutex_owner = '0;
					o.status = ST_RELEASED;
				end
			end
			default: begin
				if (at < 0) begin
					o.status = ST_NOTFOUND;
				end else begin
					wait_line.delete(at);
					o.wake_valid = 1'b1;
					o.wake_job = job;
					o.status = ST_REMOVED;
				end
			end
		endcase
		o.owner_valid = mutex_held;
		o.owner_job = mutex_held ? mutex_owner : '0;
		return o;
	endfunction

	// Watch both channels at each rising edge.
	always @(posedge clk) begin : watch
		lock_outcome_t got;
		lock_outcome_t want;
		logic [N_JOBS-1:0] mask;
		if (!arst_n) begin
			mutex_held = 1'b0;
			mutex_owner = '0;
			wait_line.delete();
			owed_outcomes.delete();
		end else begin
			// A result leaves the block and is held against the oldest prediction.
			if (rsp.valid && rsp.ready) begin
				got = '{status_t'(rsp.status), rsp.wake_valid, rsp.wake_job,
					rsp.owner_valid, rsp.owner_job};
				if (owed_outcomes.size() == 0) begin
					report_mismatch("status of a result with no request waiting",
						got.status, -1);
				end else begin
					want = owed_outcomes.pop_front();
					if (got.status != want.status)
						report_mismatch("status", got.status, want.status);
					if (got.wake_valid != want.wake_valid)
						report_mismatch("wake_valid", got.wake_valid, want.wake_valid);
					if (got.wake_job != want.wake_job)
						report_mismatch("wake_job", got.wake_job, want.wake_job);
					if (got.owner_valid != want.owner_valid)
						report_mismatch("owner_valid", got.owner_valid, want.owner_valid);
					if (got.owner_job != want.owner_job)
						report_mismatch("owner_job", got.owner_job, want.owner_job);
				end
			end
			// A request enters and its result is predicted at once.
			if (req.valid && req.ready)
				owed_outcomes.push_back(predict_lock_outcome(opcode_t'(req.opcode), req.job_id));
		end
		mask = '0;
		foreach (wait_line[i]) mask[wait_line[i]] = 1'b1;
		owed_count <= owed_outcomes.size();
		held_seen <= mutex_held;
		owner_seen <= mutex_owner;
		waiting_seen <= mask;
	end

endmodule

`default_nettype wire

### tb/sv/fifo_handoff_mutex_core_test.sv
// Top of the lock manager testbench: clock, reset, request stimulus and the verdict.
`default_nettype none

module fifo_handoff_mutex_core_test;
	import fhm_pkg::*;

	localparam int JOB_BITS        = JOB_ID_BITS_DEF;
	localparam int DEPTH           = QUEUE_DEPTH_DEF;
	localparam int N_JOBS          = 1 << JOB_BITS;
	localparam int RANDOM_REQUESTS = 400;
	localparam int QUIET_LIMIT     = 1000;
	localparam int SETTLE_CYCLES   = 2 * DEPTH + 8;

	typedef logic [JOB_BITS-1:0] job_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              no_idle;
	int                fail_count;
	int                outstanding;
	logic              held_hint;
	job_t              owner_hint;
	logic [N_JOBS-1:0] waiting_mask;
	int                quiet_cycles = 0;

	fhm_req_if #(.JOB_ID_BITS(JOB_BITS)) req_ch ();
	fhm_rsp_if #(.JOB_ID_BITS(JOB_BITS)) rsp_ch ();

	fifo_handoff_mutex_core #(
		.JOB_ID_BITS(JOB_BITS),
		.QUEUE_DEPTH(DEPTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	fhm_lock_checker #(
		.JOB_ID_BITS(JOB_BITS),
		.QUEUE_DEPTH(DEPTH)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.held_hint    (held_hint),
		.owner_hint   (owner_hint),
		.waiting_mask (waiting_mask)
	);

	always #2 clk = ~clk;

	// The receiver stalls at random, except while the steady stretch runs.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= no_idle || ($urandom_range(99) >= 35);
		end
	end

	// Ends the run when nothing has moved on either channel for too long.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Presents one request, after a random gap outside the steady stretch, and waits until it is taken.
	task automatic send_request(opcode_t op, job_t job);
		while (!no_idle && $urandom_range(99) < 35) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.job_id <= job;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Holds requests back until every outstanding result has come out.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Picks a random job from a set, or any job if the set is empty.
	function automatic job_t pick_job(logic [N_JOBS-1:0] pool);
		job_t cands[$];
		for (int j = 0; j < N_JOBS; j++) begin
			if (pool[j]) cands.push_back(job_t'(j));
		end
		if (cands.size() == 0) return job_t'($urandom_range(N_JOBS - 1));
		return cands[$urandom_range(cands.size() - 1)];
	endfunction

	initial begin : stimulus
		int sent;
		int next_fill;
		int k;
		int r;
		bit drained_once;
		job_t order[N_JOBS];
		job_t tmp;
		logic [N_JOBS-1:0] free_pool;

		arst_n <= 1'b0;
		no_idle <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_LOCK;
		req_ch.job_id <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: grants, busy answers, misuse, queueing, cancel and hand-over.
		send_request(OP_TRYLOCK, 4'd0);
		send_request(OP_TRYLOCK, 4'd15);
		send_request(OP_TRYLOCK, 4'd0);
		send_request(OP_LOCK, 4'd0);
		send_request(OP_LOCK, 4'd15);
		send_request(OP_LOCK, 4'd5);
		send_request(OP_LOCK, 4'd15);
		send_request(OP_CANCEL, 4'd9);
		send_request(OP_CANCEL, 4'd15);
		send_request(OP_UNLOCK, 4'd3);
		send_request(OP_UNLOCK, 4'd0);
		send_request(OP_UNLOCK, 4'd5);
		send_request(OP_UNLOCK, 4'd5);
		send_request(OP_CANCEL, 4'd0);
		send_request(OP_LOCK, 4'd15);
		send_request(OP_LOCK, 4'd0);
		send_request(OP_LOCK, 4'd10);
		send_request(OP_LOCK, 4'd3);
		send_request(OP_CANCEL, 4'd3);
		send_request(OP_CANCEL, 4'd0);
		send_request(OP_UNLOCK, 4'd15);
		send_request(OP_UNLOCK, 4'd10);
		wait_drained();

		// Random part: mostly requests that make sense for the current state.
		sent = 0;
		next_fill = 10;
		drained_once = 1'b0;
		while (sent < RANDOM_REQUESTS) begin
			no_idle <= (sent >= 150 && sent < 250);
			if (!drained_once && sent >= 200) begin
				wait_drained();
				drained_once = 1'b1;
			end
			// Now and then every job asks for the lock, in shuffled order, to fill the queue.
			if (sent >= next_fill) begin
				for (k = 0; k < N_JOBS; k++) order[k] = job_t'(k);
				for (k = N_JOBS - 1; k > 0; k--) begin
					r = $urandom_range(k);
					tmp = order[k];
					order[k] = order[r];
					order[r] = tmp;
				end
				for (k = 0; k < N_JOBS; k++) send_request(OP_LOCK, order[k]);
				sent += N_JOBS;
				next_fill += 120;
			end
			free_pool = ~waiting_mask;
			if (held_hint) free_pool[owner_hint] = 1'b0;
			r = $urandom_range(99);
			if (r < 10)
				send_request(opcode_t'($urandom_range(3)), job_t'($urandom_range(N_JOBS - 1)));
			else if (r < 40)
				send_request(OP_LOCK, pick_job(free_pool));
			else if (r < 52)
				send_request(OP_TRYLOCK, job_t'($urandom_range(N_JOBS - 1)));
			else if (r < 78)
				send_request(OP_UNLOCK,
					held_hint ? owner_hint : job_t'($urandom_range(N_JOBS - 1)));
			else
				send_request(OP_CANCEL, pick_job(waiting_mask));
			sent++;
		end

		// Let the last results out, then give the block time to go quiet.
		no_idle <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

### fifo_handoff_mutex_core.f
hw/rtl/fhm_pkg.sv
hw/rtl/fhm_req_if.sv
hw/rtl/fhm_rsp_if.sv
hw/rtl/fhm_ram.sv
hw/rtl/fhm_ctrl.sv
hw/rtl/fhm_out.sv
hw/rtl/fifo_handoff_mutex_core.sv
hw/rtl/fhm_checker.sv
tb/sv/fhm_lock_checker.sv
tb/sv/fifo_handoff_mutex_core_test.sv
